// ----- src/brl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brl_pkg
// types and constants shared by the line rasterizer files
// ----------------------------------------------------------------------------
package brl_pkg;

  localparam int COORD_BITS = 12;
  localparam int DELTA_BITS = COORD_BITS + 1;
  localparam int DEC_BITS   = COORD_BITS + 4;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DELTA_BITS-1:0] diff_t;
  typedef logic        [DELTA_BITS-1:0] delta_t;
  typedef logic signed [DEC_BITS-1:0]   dec_t;

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } opcode_t;

  // walk state of one line
  typedef struct packed {
    coord_t cur_x;
    coord_t cur_y;
    delta_t remaining;
    dec_t   decision;
    delta_t major_delta;
    delta_t minor_delta;
    logic   major_is_y;
    logic   major_step_neg;
    logic   minor_step_neg;
  } line_t;

endpackage

// ----- src/brl_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brl_in_if
// command channel: start or step items with endpoint payload
// ----------------------------------------------------------------------------
interface brl_in_if import brl_pkg::*; ();

  logic   valid;
  logic   ready;
  logic   opcode;
  coord_t start_x;
  coord_t start_y;
  coord_t end_x;
  coord_t end_y;

  modport source (output valid, opcode, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, opcode, start_x, start_y, end_x, end_y, output ready);

endinterface

// ----- src/brl_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brl_out_if
// pixel channel: one pixel per item with end-of-line mark
// ----------------------------------------------------------------------------
interface brl_out_if import brl_pkg::*; ();

  logic   valid;
  logic   ready;
  coord_t pixel_x;
  coord_t pixel_y;
  logic   last;

  modport source (output valid, pixel_x, pixel_y, last, input ready);
  modport sink   (input valid, pixel_x, pixel_y, last, output ready);

endinterface

// ----- src/bresenham_line_rasterizer_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer_top
// integer line walker: one pixel per step item
// ----------------------------------------------------------------------------
// usage
//   cmd carries items: opcode start loads both endpoints and gives no pixel,
//   opcode step gives the next pixel of the loaded line on pix
//   the final pixel of a line has last set; steps with no line loaded are
//   swallowed; a start while a line is running replaces it
// timing
//   one item per cycle sustained unless pix stalls; a start may be followed
//   by a step in the very next cycle since the line setup is a single
//   subtract/abs/compare stage written straight into the walk registers
//   a pixel appears on pix in the cycle after its step item is accepted
//   each pixel costs one add and compare on the decision register
// stall
//   pix is held in an output register; cmd.ready stays high as long as that
//   register is empty or is being drained in the same cycle, so a stalled
//   receiver stops the command side after at most one pending pixel
// reset
//   rst is synchronous; afterwards no line is loaded and pix is empty
// ----------------------------------------------------------------------------
module bresenham_line_rasterizer_top import brl_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  brl_in_if.sink        cmd,
  brl_out_if.source     pix
);

  // walk state
  logic  active;
  line_t line;
  line_t line_load;
  line_t line_next;

  logic  accept;
  logic  is_start;
  logic  do_step;
  logic  advance;
  logic  last_px;
  logic  x_moves;
  logic  y_moves;
  logic  x_neg;
  logic  y_neg;

  // output register
  logic   out_valid;
  coord_t out_x;
  coord_t out_y;
  logic   out_last;

  brl_setup u_setup (
    .start_x (cmd.start_x),
    .start_y (cmd.start_y),
    .end_x   (cmd.end_x),
    .end_y   (cmd.end_y),
    .line    (line_load)
  );

  assign cmd.ready = !out_valid || pix.ready;
  assign accept    = cmd.valid && cmd.ready;
  assign is_start  = (cmd.opcode == OP_START);
  assign do_step   = accept && (cmd.opcode == OP_STEP) && active;

  // minor axis moves only on a strictly positive decision
  assign advance = !line.decision[DEC_BITS-1] && (line.decision != '0);
  assign last_px = (line.remaining == delta_t'(1));

  assign x_moves = line.major_is_y ? advance : 1'b1;
  assign y_moves = line.major_is_y ? 1'b1 : advance;
  assign x_neg   = line.major_is_y ? line.minor_step_neg : line.major_step_neg;
  assign y_neg   = line.major_is_y ? line.major_step_neg : line.minor_step_neg;

  always_comb begin
    line_next = line;
    if (x_moves) begin
      line_next.cur_x = x_neg ? line.cur_x - coord_t'(1) : line.cur_x + coord_t'(1);
    end
    if (y_moves) begin
      line_next.cur_y = y_neg ? line.cur_y - coord_t'(1) : line.cur_y + coord_t'(1);
    end
    line_next.decision = line.decision + dec_t'({line.minor_delta, 1'b0})
                       - (advance ? dec_t'({line.major_delta, 1'b0}) : '0);
    line_next.remaining = line.remaining - delta_t'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept && is_start) begin
        active <= 1'b1;
        line   <= line_load;
      end else if (do_step) begin
        active <= !last_px;
        line   <= line_next;
      end
      if (do_step) begin
        out_valid <= 1'b1;
        out_x     <= line.cur_x;
        out_y     <= line.cur_y;
        out_last  <= last_px;
      end else if (pix.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign pix.valid   = out_valid;
  assign pix.pixel_x = out_x;
  assign pix.pixel_y = out_y;
  assign pix.last    = out_last;

`ifndef SYNTHESIS
  // a running line always has pixels left
  a_active_nonzero: assert property (@(posedge clk) disable iff (rst)
    active |-> (line.remaining != '0))
    else $error("active line with no pixels left");

  // the final pixel always ends the line
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    do_step && last_px |=> !active)
    else $error("line still active after its last pixel");

  // a start always leaves a line loaded
  a_start_loads: assert property (@(posedge clk) disable iff (rst)
    accept && is_start |=> active)
    else $error("start item did not load a line");

  // a held pixel blocks the command side
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    out_valid && !pix.ready |-> !cmd.ready)
    else $error("command taken while pixel stalled");

  // a pixel appears only after an accepted step on a running line
  a_pixel_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(do_step))
    else $error("pixel without a step");
`endif

endmodule

// ----- src/brl_setup.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brl_setup
// derives the initial walk state of a line from its two endpoints
// ----------------------------------------------------------------------------
module brl_setup import brl_pkg::*; (
  input  coord_t start_x,
  input  coord_t start_y,
  input  coord_t end_x,
  input  coord_t end_y,
  output line_t  line
);

  diff_t  dx;
  diff_t  dy;
  delta_t adx;
  delta_t ady;
  logic   axis;
  logic   y_major;
  logic   swap;
  delta_t major;
  delta_t minor;

  assign dx  = diff_t'(end_x) - diff_t'(start_x);
  assign dy  = diff_t'(end_y) - diff_t'(start_y);
  assign adx = dx[DELTA_BITS-1] ? delta_t'(-dx) : delta_t'(dx);
  assign ady = dy[DELTA_BITS-1] ? delta_t'(-dy) : delta_t'(dy);

  assign axis    = (dx == '0) || (dy == '0);
  assign y_major = axis ? (dy != '0) : (ady > adx);
  // sloped lines start from the endpoint lower on the major axis
  assign swap    = !axis && (y_major ? dy[DELTA_BITS-1] : dx[DELTA_BITS-1]);
  assign major   = y_major ? ady : adx;
  assign minor   = axis ? '0 : (y_major ? adx : ady);

  always_comb begin
    line.cur_x       = swap ? end_x : start_x;
    line.cur_y       = swap ? end_y : start_y;
    line.major_delta = major;
    line.minor_delta = minor;
    line.major_is_y  = y_major;
    if (axis) begin
      line.major_step_neg = y_major ? dy[DELTA_BITS-1] : (dx[DELTA_BITS-1] || (dx == '0));
      line.minor_step_neg = 1'b0;
    end else begin
      line.major_step_neg = 1'b0;
      line.minor_step_neg = y_major ? (dx[DELTA_BITS-1] ^ swap) : (dy[DELTA_BITS-1] ^ swap);
    end
    line.decision  = dec_t'({minor, 1'b0}) - dec_t'(major);
    line.remaining = major + delta_t'(1);
  end

endmodule
